### rtl/core/rrqs_pkg.sv
//------------------------------------------------------------------------------
// rrqs_pkg
// Shared types and constants of the round-robin quantum scheduler: request
// and result item layouts, request kinds, register map and reset values.
//------------------------------------------------------------------------------
`default_nettype none

package rrqs_pkg;

	// Default number of process slots
	localparam int unsigned MAX_PROCS_DEF = 16;

	// Field widths fixed by the item layouts
	localparam int unsigned PID_OUT_W = 5;
	localparam int unsigned CNT_OUT_W = 5;
	localparam int unsigned TIME_W    = 48;
	localparam int unsigned ARR_W     = 32;
	localparam int unsigned DUR_W     = 16;
	localparam int unsigned LINE_W    = 16;
	localparam int unsigned ACCUM_W   = 17;
	localparam int unsigned QUANTUM_W = 16;

	// Configuration port
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic        REG_QUANTUM_IDX = 1'b0;
	localparam logic [QUANTUM_W-1:0] QUANTUM_RST = 16'd100;

	// Request kinds
	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_INSTR = 2'd2;

	typedef struct packed {
		logic [1:0]       kind;
		logic [ARR_W-1:0] arrive_at;
		logic [DUR_W-1:0] duration;
		logic             is_exit;
	} req_item_t;

	typedef struct packed {
		logic [TIME_W-1:0]    now_time;
		logic [PID_OUT_W-1:0] finished_pid;
		logic                 finished_exit;
		logic                 next_valid;
		logic [PID_OUT_W-1:0] next_pid;
		logic [LINE_W-1:0]    resume_line;
		logic [CNT_OUT_W-1:0] ready_count;
		logic                 all_done;
	} res_item_t;

endpackage

`default_nettype wire

### rtl/core/rrqs_ram.sv
//------------------------------------------------------------------------------
// rrqs_ram
// Simple dual-port synchronous RAM: one write port, one read port, read data
// registered.
//------------------------------------------------------------------------------
`default_nettype none

module rrqs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/rrqs_ctrl.sv
//------------------------------------------------------------------------------
// rrqs_ctrl
// Scheduler sequencer: decodes each request, updates the per-process line
// counts, admits due arrivals, re-queues or retires the running process and
// dispatches the next one, all through the three state memories.
//------------------------------------------------------------------------------
`default_nettype none

module rrqs_ctrl import rrqs_pkg::*; #(
	parameter int unsigned MAX_PROCS = MAX_PROCS_DEF,
	localparam int unsigned IDX_W = $clog2(MAX_PROCS),
	localparam int unsigned PID_W = $clog2(MAX_PROCS + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [QUANTUM_W-1:0] quantum,
	// Request channel
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire req_item_t            req_item,
	// Result channel
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output res_item_t                 res_item,
	// Arrival store
	output logic                      arr_we,
	output logic      [IDX_W-1:0]     arr_waddr,
	output logic      [ARR_W-1:0]     arr_wdata,
	output logic      [IDX_W-1:0]     arr_raddr,
	input  wire logic [ARR_W-1:0]     arr_rdata,
	// Ready queue
	output logic                      fifo_we,
	output logic      [IDX_W-1:0]     fifo_waddr,
	output logic      [PID_W-1:0]     fifo_wdata,
	output logic      [IDX_W-1:0]     fifo_raddr,
	input  wire logic [PID_W-1:0]     fifo_rdata,
	// Executed line counts
	output logic                      ex_we,
	output logic      [IDX_W-1:0]     ex_waddr,
	output logic      [LINE_W-1:0]    ex_wdata,
	output logic      [IDX_W-1:0]     ex_raddr,
	input  wire logic [LINE_W-1:0]    ex_rdata
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_EXEC_UPD,
		ST_ADM_RD,
		ST_ADM_CHK,
		ST_REQUEUE,
		ST_DISP,
		ST_DISP_POP,
		ST_DISP_ARR,
		ST_DISP_LINE,
		ST_RESULT
	} state_t;

	localparam logic [PID_W-1:0] PROCS_FULL = PID_W'(MAX_PROCS);
	localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(MAX_PROCS - 1);

	state_t              state_q;
	req_item_t           item_q;
	logic [PID_W-1:0]    loaded_q;
	logic [PID_W-1:0]    nai_q;
	logic [IDX_W-1:0]    head_q;
	logic [IDX_W-1:0]    tail_q;
	logic [PID_W-1:0]    count_q;
	logic [PID_W-1:0]    running_q;
	logic [ACCUM_W-1:0]  accum_q;
	logic [TIME_W-1:0]   time_q;
	logic [PID_W-1:0]    completed_q;
	logic [PID_W-1:0]    fin_pid_q;
	logic                fin_exit_q;
	logic [PID_W-1:0]    next_pid_q;
	logic [LINE_W-1:0]   resume_q;
	logic                out_vld_q;
	res_item_t           out_q;
	logic [MAX_PROCS-1:0] ex_vld_q;
	logic                ex_hit_q;

	logic [LINE_W-1:0]   ex_cur;
	logic [TIME_W:0]     time_sum;
	logic [TIME_W-1:0]   time_adv;
	logic [TIME_W-1:0]   arr_ext;
	logic                arr_due;
	logic                slice_end;
	logic                fifo_room;
	logic                arr_pending;
	logic                res_free;
	res_item_t           res_build;

	function automatic logic [IDX_W-1:0] ptr_next(input logic [IDX_W-1:0] p);
		ptr_next = (p == IDX_LAST) ? '0 : p + 1'b1;
	endfunction

	// Line count of the entry read last cycle; never-written entries read zero
	assign ex_cur = ex_hit_q ? ex_rdata : '0;

	// Slice end time, saturating
	assign time_sum = {1'b0, time_q} + (TIME_W + 1)'(accum_q);
	assign time_adv = time_sum[TIME_W] ? '1 : time_sum[TIME_W-1:0];

	assign arr_ext     = TIME_W'(arr_rdata);
	assign arr_due     = (arr_ext <= time_q);
	assign slice_end   = item_q.is_exit || (accum_q >= ACCUM_W'(quantum));
	assign fifo_room   = (count_q != PROCS_FULL);
	assign arr_pending = (nai_q < loaded_q);
	assign res_free    = !out_vld_q || res_ready;

	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = out_vld_q;
	assign res_item  = out_q;

	// Memory port drive
	always_comb begin
		arr_we     = (state_q == ST_DECODE) && (item_q.kind == KIND_LOAD) &&
		             (loaded_q != PROCS_FULL);
		arr_waddr  = IDX_W'(loaded_q);
		arr_wdata  = item_q.arrive_at;
		arr_raddr  = IDX_W'(nai_q);

		fifo_we    = ((state_q == ST_ADM_CHK) && arr_due) ||
		             ((state_q == ST_REQUEUE) && !item_q.is_exit && fifo_room);
		fifo_waddr = tail_q;
		fifo_wdata = (state_q == ST_ADM_CHK) ? nai_q + 1'b1 : running_q;
		fifo_raddr = head_q;

		ex_we      = (state_q == ST_EXEC_UPD);
		ex_waddr   = IDX_W'(running_q - 1'b1);
		ex_wdata   = (ex_cur == '1) ? ex_cur : ex_cur + 1'b1;
		unique case (state_q)
			ST_DISP_POP: ex_raddr = IDX_W'(fifo_rdata - 1'b1);
			ST_DISP_ARR: ex_raddr = IDX_W'(nai_q);
			default:     ex_raddr = IDX_W'(running_q - 1'b1);
		endcase
	end

	// Result item as it leaves the sequencer
	always_comb begin
		res_build.now_time      = time_q;
		res_build.finished_pid  = PID_OUT_W'(fin_pid_q);
		res_build.finished_exit = fin_exit_q;
		res_build.next_valid    = (next_pid_q != '0);
		res_build.next_pid      = PID_OUT_W'(next_pid_q);
		res_build.resume_line   = resume_q;
		res_build.ready_count   = CNT_OUT_W'(count_q);
		res_build.all_done      = (completed_q == loaded_q);
	end

	// Valid bits and read hit of the line count store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ex_vld_q <= '0;
			ex_hit_q <= 1'b0;
		end else begin
			ex_hit_q <= ex_vld_q[ex_raddr];
			if (ex_we) begin
				ex_vld_q[ex_waddr] <= 1'b1;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			loaded_q    <= '0;
			nai_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			running_q   <= '0;
			accum_q     <= '0;
			time_q      <= '0;
			completed_q <= '0;
			fin_pid_q   <= '0;
			fin_exit_q  <= 1'b0;
			next_pid_q  <= '0;
			resume_q    <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			// raise the result once built, drop it once taken
			if ((state_q == ST_RESULT) && res_free) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && res_ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_DECODE;
					end
				end

				ST_DECODE: begin
					unique case (item_q.kind)
						KIND_LOAD: begin
							if (loaded_q != PROCS_FULL) begin
								loaded_q <= loaded_q + 1'b1;
							end
							state_q <= ST_IDLE;
						end
						KIND_START: begin
							if (running_q != '0) begin
								state_q <= ST_IDLE;
							end else begin
								fin_pid_q  <= '0;
								fin_exit_q <= 1'b0;
								state_q    <= ST_DISP;
							end
						end
						KIND_INSTR: begin
							if (running_q == '0) begin
								state_q <= ST_IDLE;
							end else begin
								accum_q <= accum_q + ACCUM_W'(item_q.duration);
								state_q <= ST_EXEC_UPD;
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end

				// line count written back by the memory port; close the slice if it ends
				ST_EXEC_UPD: begin
					if (slice_end) begin
						time_q     <= time_adv;
						fin_pid_q  <= running_q;
						fin_exit_q <= item_q.is_exit;
						state_q    <= ST_ADM_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end

				// walk the pending arrivals in load order
				ST_ADM_RD: begin
					state_q <= (arr_pending && fifo_room) ? ST_ADM_CHK : ST_REQUEUE;
				end

				ST_ADM_CHK: begin
					if (arr_due) begin
						nai_q   <= nai_q + 1'b1;
						tail_q  <= ptr_next(tail_q);
						count_q <= count_q + 1'b1;
						state_q <= ST_ADM_RD;
					end else begin
						state_q <= ST_REQUEUE;
					end
				end

				// retire or re-queue the finished process
				ST_REQUEUE: begin
					if (item_q.is_exit) begin
						completed_q <= completed_q + 1'b1;
					end else if (fifo_room) begin
						tail_q  <= ptr_next(tail_q);
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_DISP;
				end

				ST_DISP: begin
					accum_q <= '0;
					if (count_q != '0) begin
						head_q  <= ptr_next(head_q);
						count_q <= count_q - 1'b1;
						state_q <= ST_DISP_POP;
					end else if (arr_pending) begin
						state_q <= ST_DISP_ARR;
					end else begin
						running_q  <= '0;
						next_pid_q <= '0;
						resume_q   <= '0;
						state_q    <= ST_RESULT;
					end
				end

				ST_DISP_POP: begin
					running_q  <= fifo_rdata;
					next_pid_q <= fifo_rdata;
					state_q    <= ST_DISP_LINE;
				end

				// idle queue: jump to the next arrival, never back in time
				ST_DISP_ARR: begin
					if (arr_ext > time_q) begin
						time_q <= arr_ext;
					end
					nai_q      <= nai_q + 1'b1;
					running_q  <= nai_q + 1'b1;
					next_pid_q <= nai_q + 1'b1;
					state_q    <= ST_DISP_LINE;
				end

				ST_DISP_LINE: begin
					resume_q <= ex_cur;
					state_q  <= ST_RESULT;
				end

				// hold until the output register is free
				ST_RESULT: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_q <= req_item;
		end
		if ((state_q == ST_RESULT) && res_free) begin
			out_q <= res_build;
		end
	end

endmodule

`default_nettype wire

### rtl/core/round_robin_quantum_scheduler.sv
// Requests are handled one at a time by the single sequencer walking the arrival
// store, ready queue and line count memories; a new request is taken only once
// the previous one is done. A finished result waits in ST_RESULT until the result
// register is free; once loaded there, it no longer holds up the request side.
// Reset: arst_n clears all control state and sets the quantum to 100.
//------------------------------------------------------------------------------
// round_robin_quantum_scheduler
// Round-robin process scheduler with a time quantum; APB register for the
// quantum, request and result channels with valid/ready handshakes.
//------------------------------------------------------------------------------
`default_nettype none

module round_robin_quantum_scheduler import rrqs_pkg::*; #(
	parameter int unsigned MAX_PROCS = MAX_PROCS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	// Request channel
	input  wire logic                  req_valid,
	output logic                       req_ready,
	input  wire req_item_t             req_item,
	// Result channel
	output logic                       res_valid,
	input  wire logic                  res_ready,
	output res_item_t                  res_item
);

	localparam int unsigned IDX_W = $clog2(MAX_PROCS);
	localparam int unsigned PID_W = $clog2(MAX_PROCS + 1);

	logic [QUANTUM_W-1:0] quantum_q;
	logic                 reg_sel;

	logic             arr_we;
	logic [IDX_W-1:0] arr_waddr;
	logic [ARR_W-1:0] arr_wdata;
	logic [IDX_W-1:0] arr_raddr;
	logic [ARR_W-1:0] arr_rdata;

	logic             fifo_we;
	logic [IDX_W-1:0] fifo_waddr;
	logic [PID_W-1:0] fifo_wdata;
	logic [IDX_W-1:0] fifo_raddr;
	logic [PID_W-1:0] fifo_rdata;

	logic              ex_we;
	logic [IDX_W-1:0]  ex_waddr;
	logic [LINE_W-1:0] ex_wdata;
	logic [IDX_W-1:0]  ex_raddr;
	logic [LINE_W-1:0] ex_rdata;

	// Register decode
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_QUANTUM_IDX);
	assign prdata  = reg_sel ? APB_DATA_W'(quantum_q) : '0;

	// Quantum register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			quantum_q <= pwdata[QUANTUM_W-1:0];
		end
	end

	rrqs_ctrl #(
		.MAX_PROCS(MAX_PROCS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.quantum    (quantum_q),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_item   (req_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item),
		.arr_we     (arr_we),
		.arr_waddr  (arr_waddr),
		.arr_wdata  (arr_wdata),
		.arr_raddr  (arr_raddr),
		.arr_rdata  (arr_rdata),
		.fifo_we    (fifo_we),
		.fifo_waddr (fifo_waddr),
		.fifo_wdata (fifo_wdata),
		.fifo_raddr (fifo_raddr),
		.fifo_rdata (fifo_rdata),
		.ex_we      (ex_we),
		.ex_waddr   (ex_waddr),
		.ex_wdata   (ex_wdata),
		.ex_raddr   (ex_raddr),
		.ex_rdata   (ex_rdata)
	);

	// Arrival times in load order
	rrqs_ram #(
		.WIDTH(ARR_W),
		.DEPTH(MAX_PROCS)
	) u_arr_ram (
		.clk   (clk),
		.we    (arr_we),
		.waddr (arr_waddr),
		.wdata (arr_wdata),
		.raddr (arr_raddr),
		.rdata (arr_rdata)
	);

	// Ready queue entries
	rrqs_ram #(
		.WIDTH(PID_W),
		.DEPTH(MAX_PROCS)
	) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (fifo_waddr),
		.wdata (fifo_wdata),
		.raddr (fifo_raddr),
		.rdata (fifo_rdata)
	);

	// Executed lines per process
	rrqs_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_PROCS)
	) u_ex_ram (
		.clk   (clk),
		.we    (ex_we),
		.waddr (ex_waddr),
		.wdata (ex_wdata),
		.raddr (ex_raddr),
		.rdata (ex_rdata)
	);

endmodule

`default_nettype wire

### bench/round_robin_quantum_scheduler_tb.sv
//------------------------------------------------------------------------------
// round_robin_quantum_scheduler_tb
// Self-checking bench for the round-robin quantum scheduler. Drives process
// loads, start requests and instruction completions over the request channel.
// The quantum register is set over APB between phases. A cycle-free model of
// the ready queue, slice accounting and time predicts every result, and the
// bench compares each result field by field with the oldest prediction.
//------------------------------------------------------------------------------

module round_robin_quantum_scheduler_tb import rrqs_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam int unsigned SLOTS = MAX_PROCS_DEF;
	localparam logic [APB_ADDR_W-1:0] REG_QUANTUM_ADDR = APB_ADDR_W'(4 * REG_QUANTUM_IDX);
	localparam int unsigned STALL_LIMIT = 4000;
	localparam int unsigned SETTLE_CYCLES = 64;

	// Scheduler model plus the store of results still owed by the block
	class schedule_board;
		logic [15:0] quantum;
		logic [31:0] arrival_mem [SLOTS];
		logic [15:0] line_count [SLOTS];
		logic [4:0]  ready_q [$];
		int unsigned loaded, next_arrival, completed, running;
		logic [16:0] accum;
		logic [47:0] now;
		res_item_t   pending [$];
		int unsigned acted, results, errors;

		function void clear();
			quantum = QUANTUM_RST;
			foreach (line_count[i]) line_count[i] = '0;
			ready_q.delete();
			pending.delete();
			loaded = 0;
			next_arrival = 0;
			completed = 0;
			running = 0;
			accum = '0;
			now = '0;
			acted = 0;
			results = 0;
			errors = 0;
		endfunction

		// Pick the next process: queue head first, else jump to the next arrival
		function void dispatch_next(inout res_item_t e);
			int unsigned pid = 0;
			if (ready_q.size() != 0) begin
				pid = ready_q.pop_front();
			end else if (next_arrival < loaded) begin
				if (arrival_mem[next_arrival] > now)
					now = {16'h0, arrival_mem[next_arrival]};
				next_arrival++;
				pid = next_arrival;
			end
			running = pid;
			accum = '0;
			e.now_time = now;
			e.next_valid = (pid != 0);
			e.next_pid = 5'(pid);
			e.resume_line = (pid != 0) ? line_count[pid - 1] : '0;
			e.ready_count = 5'(ready_q.size());
			e.all_done = (completed == loaded);
		endfunction

		function void note_request(req_item_t r);
			res_item_t e;
			int unsigned pid;
			logic [48:0] sum;
			e = '0;
			case (r.kind)
			KIND_LOAD: begin
				if (loaded < SLOTS) begin
					arrival_mem[loaded] = r.arrive_at;
					loaded++;
					acted++;
				end
			end
			KIND_START: begin
				if (running == 0) begin
					dispatch_next(e);
					pending.push_back(e);
					acted++;
				end
			end
			KIND_INSTR: begin
				if (running != 0) begin
					acted++;
					pid = running;
					accum = accum + 17'(r.duration);
					if (line_count[pid - 1] != 16'hFFFF)
						line_count[pid - 1]++;
					if (r.is_exit || accum >= {1'b0, quantum}) begin
						// Advance time with saturation, then admit every due arrival while the queue has room
						sum = {1'b0, now} + 49'(accum);
						now = sum[48] ? '1 : sum[47:0];
						while (next_arrival < loaded && arrival_mem[next_arrival] <= now &&
								ready_q.size() < SLOTS) begin
							next_arrival++;
							ready_q.push_back(5'(next_arrival));
						end
						if (r.is_exit) begin
							if (completed < 31)
								completed++;
						end else if (ready_q.size() < SLOTS) begin
							ready_q.push_back(5'(pid));
						end
						e.finished_pid = 5'(pid);
						e.finished_exit = r.is_exit;
						dispatch_next(e);
						pending.push_back(e);
					end
				end
			end
			default: ;
			endcase
		endfunction

		function void check_field(string name, logic [47:0] want, logic [47:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(res_item_t got);
			res_item_t want;
			if (pending.size() == 0) begin
				$error("result with no request outstanding: %p", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			results++;
			check_field("now_time", want.now_time, got.now_time);
			check_field("finished_pid", want.finished_pid, got.finished_pid);
			check_field("finished_exit", want.finished_exit, got.finished_exit);
			check_field("next_valid", want.next_valid, got.next_valid);
			check_field("next_pid", want.next_pid, got.next_pid);
			check_field("resume_line", want.resume_line, got.resume_line);
			check_field("ready_count", want.ready_count, got.ready_count);
			check_field("all_done", want.all_done, got.all_done);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic req_valid = 1'b0;
	logic req_ready;
	req_item_t req_item = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_item_t res_item;

	schedule_board sb = new;

	// Stimulus knobs, set per phase, then the stall and quiet counters
	int unsigned idle_pct = 0;
	int unsigned load_cap = 0;
	int unsigned exit_permille = 0;
	int unsigned res_hold = 0;
	int unsigned quiet_cycles = 0;

	round_robin_quantum_scheduler dut (
		.clk,
		.arst_n,
		.psel,
		.penable,
		.pwrite,
		.paddr,
		.pwdata,
		.prdata,
		.pready,
		.req_valid,
		.req_ready,
		.req_item,
		.res_valid,
		.res_ready,
		.res_item
	);

	always #2ns clk = ~clk;

	// Observe both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready)
				sb.note_request(req_item);
			if (res_valid && res_ready)
				sb.check_result(res_item);
		end
	end

	// Count cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (res_valid && res_ready) ||
				(psel && penable && pready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("round_robin_quantum_scheduler: mismatch");
		$finish;
	end

	// Stall the result side in random bursts
	always @(negedge clk) begin
		if (res_hold != 0) begin
			res_hold <= res_hold - 1;
			res_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			res_hold <= $urandom_range(0, 16);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	task automatic apb_access(input logic write, input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] wdata, output logic [APB_DATA_W-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= addr;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic verify_quantum(input logic [15:0] want);
		logic [APB_DATA_W-1:0] rd;
		apb_access(1'b0, REG_QUANTUM_ADDR, '0, rd);
		if (rd !== {16'h0, want}) begin
			$error("quantum readback: expected %0d, actual %0d", want, rd);
			sb.errors++;
		end
	endtask

	task automatic write_quantum(input logic [15:0] q);
		logic [APB_DATA_W-1:0] rd;
		apb_access(1'b1, REG_QUANTUM_ADDR, {16'h0, q}, rd);
		sb.quantum = q;
		verify_quantum(q);
	endtask

	// Present one request, hold it until taken, then maybe idle
	task automatic push_request(input req_item_t r);
		req_item <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		@(negedge clk);
		if ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
	endtask

	// Drain outstanding results and let any silent work finish
	task automatic wait_idle();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic req_item_t compose(input logic [1:0] k, input logic [31:0] at,
			input logic [15:0] dur, input logic ex);
		req_item_t r;
		r.kind = k;
		r.arrive_at = at;
		r.duration = dur;
		r.is_exit = ex;
		return r;
	endfunction

	// Build the next request from the model's view of the scheduler
	function automatic req_item_t make_request();
		req_item_t r;
		logic [48:0] t;
		int unsigned roll;
		r.kind = KIND_INSTR;
		r.arrive_at = $urandom;
		r.duration = 16'($urandom);
		r.is_exit = 1'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			// Noise: any kind, random payload
			r.kind = 2'($urandom_range(0, 3));
			return r;
		end
		if (sb.loaded < SLOTS && ((roll < 20 && sb.loaded < load_cap) ||
				(sb.running == 0 && sb.next_arrival == sb.loaded))) begin
			r.kind = KIND_LOAD;
			if (sb.loaded == SLOTS - 1) begin
				r.arrive_at = '1;
			end else begin
				case ($urandom_range(0, 3))
				0: begin
					t = (sb.now > 48'hFFFF_FFFF) ? 49'hFFFF_FFFF : {1'b0, sb.now};
					t = 49'($urandom_range(0, t[31:0]));
				end
				1, 2: t = {1'b0, sb.now} + 49'($urandom_range(0, 4 * sb.quantum + 50));
				default: t = {1'b0, sb.now} + 49'($urandom_range(0, 2000000));
				endcase
				r.arrive_at = (t > 49'hFFFF_FFFF) ? '1 : t[31:0];
			end
		end else if (sb.running == 0) begin
			r.kind = KIND_START;
		end else begin
			case ($urandom_range(0, 9))
			0, 1, 2, 3: r.duration = 16'($urandom_range(0, 63));
			4, 5, 6: begin
				t = 49'($urandom_range(0, 2 * sb.quantum));
				r.duration = (t > 49'hFFFF) ? '1 : t[15:0];
			end
			default: ;
			endcase
			r.is_exit = ($urandom_range(0, 999) < exit_permille);
		end
		return r;
	endfunction

	task automatic run_phase(input logic [15:0] q, input int unsigned idle, cap, exit_pm,
			count);
		int unsigned goal;
		wait_idle();
		write_quantum(q);
		idle_pct = idle;
		load_cap = cap;
		exit_permille = exit_pm;
		goal = sb.acted + count;
		while (sb.acted < goal)
			push_request(make_request());
		req_valid <= 1'b0;
	endtask

	initial begin
		sb.clear();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		verify_quantum(QUANTUM_RST);

		// Idle scheduler: stray instruction, unknown kind, start with nothing loaded
		push_request(compose(KIND_INSTR, '1, '1, 1'b1));
		push_request(compose(KIND_NONE, '0, '0, 1'b0));
		push_request(compose(KIND_START, '0, '0, 1'b0));
		// Three arrivals, start jumps time forward, repeat start is dropped
		push_request(compose(KIND_LOAD, 32'd5, '0, 1'b0));
		push_request(compose(KIND_LOAD, '0, '0, 1'b0));
		push_request(compose(KIND_LOAD, 32'd5000, '0, 1'b0));
		push_request(compose(KIND_START, '0, '0, 1'b0));
		push_request(compose(KIND_START, '1, '1, 1'b1));
		// Zero-length instruction, then a large overshoot admits both waiting arrivals
		push_request(compose(KIND_INSTR, '0, '0, 1'b0));
		push_request(compose(KIND_INSTR, '0, '1, 1'b0));
		push_request(compose(KIND_INSTR, '0, '0, 1'b1));
		// Late registration while a process runs; slice ends exactly at the quantum
		push_request(compose(KIND_LOAD, '0, '0, 1'b0));
		push_request(compose(KIND_INSTR, '0, 16'd99, 1'b0));
		push_request(compose(KIND_INSTR, '0, 16'd1, 1'b0));
		// Retire everything down to an empty scheduler
		push_request(compose(KIND_INSTR, '0, 16'd7, 1'b1));
		push_request(compose(KIND_INSTR, '0, 16'd3, 1'b1));
		push_request(compose(KIND_INSTR, '0, '0, 1'b1));
		push_request(compose(KIND_INSTR, '0, 16'd9, 1'b0));
		push_request(compose(KIND_START, '0, '0, 1'b0));
		req_valid <= 1'b0;

		// Zero quantum: every instruction ends its slice; arrival in the past keeps time
		wait_idle();
		write_quantum('0);
		push_request(compose(KIND_LOAD, 32'd100, '0, 1'b0));
		push_request(compose(KIND_START, '0, '0, 1'b0));
		push_request(compose(KIND_INSTR, '0, '0, 1'b0));
		push_request(compose(KIND_INSTR, '0, 16'd3, 1'b1));
		req_valid <= 1'b0;

		// Random phases over a range of quanta; the last one runs without idling
		run_phase(16'($urandom_range(20, 400)), 20, 8, 10, 350);
		run_phase(16'hFFFF, 50, 11, 10, 350);
		run_phase(16'd1, 0, 14, 10, 350);
		run_phase(16'($urandom_range(1, 65535)), 10, SLOTS, 10, 250);
		run_phase(QUANTUM_RST, 0, SLOTS, 150, 200);
		wait_idle();

		$display("Ran %0d effective requests and checked %0d scheduling results.",
			sb.acted, sb.results);
		$display("Loaded %0d processes, retired %0d, final time %0d.",
			sb.loaded, sb.completed, sb.now);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("round_robin_quantum_scheduler: match");
		else
			$display("round_robin_quantum_scheduler: mismatch");
		$finish;
	end

endmodule
